// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define SDI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SDI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sdi_pkg.sv =====
package sdi_pkg;

  // init phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CMD0   = 3'd1;
  localparam logic [2:0] PH_CMD8   = 3'd2;
  localparam logic [2:0] PH_ACMD41 = 3'd3;
  localparam logic [2:0] PH_CMD1   = 3'd4;
  localparam logic [2:0] PH_CMD58  = 3'd5;
  localparam logic [2:0] PH_CMD16  = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // result status codes
  localparam logic [1:0] ST_ISSUE  = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;
  localparam logic [1:0] ST_IGNORE = 2'd3;

  // request operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_RESP  = 1'b1;

  // failure causes
  localparam logic [2:0] FC_NONE         = 3'd0;
  localparam logic [2:0] FC_CMD0_SILENT  = 3'd1;
  localparam logic [2:0] FC_CMD0_NOIDLE  = 3'd2;
  localparam logic [2:0] FC_ACMD41_SILENT = 3'd3;
  localparam logic [2:0] FC_CMD1_SILENT  = 3'd4;
  localparam logic [2:0] FC_CMD1_TIMEOUT = 3'd5;
  localparam logic [2:0] FC_CMD58_SILENT = 3'd6;
  localparam logic [2:0] FC_CMD16_FAIL   = 3'd7;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_OP_COND   = 6'd1;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  // command arguments and response patterns
  localparam logic [31:0] HCS_ARG     = 32'h4000_0000;
  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  ECHO_VOLT   = 8'h01;
  localparam logic [7:0]  ECHO_PATT   = 8'hAA;

  // register map (word index)
  localparam logic [1:0] REG_ACMD41_ATTEMPTS = 2'd0;
  localparam logic [1:0] REG_SWITCH_REMAIN   = 2'd1;
  localparam logic [1:0] REG_CMD1_ATTEMPTS   = 2'd2;
  localparam logic [1:0] REG_BLOCK_LENGTH    = 2'd3;

  // register reset values
  localparam logic [15:0] RST_ACMD41_ATTEMPTS = 16'd10000;
  localparam logic [15:0] RST_SWITCH_REMAIN   = 16'd5000;
  localparam logic [15:0] RST_CMD1_ATTEMPTS   = 16'd10000;
  localparam logic [12:0] RST_BLOCK_LENGTH    = 13'd512;

  typedef struct packed {
    logic [15:0] acmd41_attempts;
    logic [15:0] acmd41_switch_remaining;
    logic [15:0] cmd1_attempts;
    logic [12:0] block_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        version_two;
    logic        arg_switched;
    logic        hcs_request;
    logic [15:0] tries_left;
    logic        card_high_capacity;
  } state_t;

  typedef struct packed {
    logic       operation;
    logic       resp_ok;
    logic [7:0] r1;
    logic [7:0] echo_voltage;
    logic [7:0] echo_pattern;
    logic [7:0] ocr_high;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [6:0]  cmd_crc;
    logic        app_prefix;
    logic        preamble;
    logic [2:0]  fail_cause;
    logic        high_capacity;
    logic        fast_clock;
  } result_t;

  // crc7 (x^7 + x^3 + 1) over start bits, index and argument, msb first;
  // linear in the message, so it reduces to an xor tree
  function automatic logic [6:0] crc7(input logic [5:0] idx, input logic [31:0] arg);
    logic [39:0] msg;
    logic [6:0]  crc;
    logic        fb;
    msg = {2'b01, idx, arg};
    crc = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = msg[i] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ 7'h09;
      end
    end
    return crc;
  endfunction

endpackage

// ===== src/sdi_req_if.sv =====
interface sdi_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       resp_ok;
  logic [7:0] r1;
  logic [7:0] echo_voltage;
  logic [7:0] echo_pattern;
  logic [7:0] ocr_high;

  modport source (output valid, operation, resp_ok, r1, echo_voltage, echo_pattern, ocr_high,
                  input ready);
  modport sink (input valid, operation, resp_ok, r1, echo_voltage, echo_pattern, ocr_high,
                output ready);
endinterface

// ===== src/sdi_rsp_if.sv =====
interface sdi_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [6:0]  cmd_crc;
  logic        app_prefix;
  logic        preamble;
  logic [2:0]  fail_cause;
  logic        high_capacity;
  logic        fast_clock;

  modport source (output valid, status, cmd_index, cmd_arg, cmd_crc, app_prefix, preamble,
                  fail_cause, high_capacity, fast_clock,
                  input ready);
  modport sink (input valid, status, cmd_index, cmd_arg, cmd_crc, app_prefix, preamble,
                fail_cause, high_capacity, fast_clock,
                output ready);
endinterface

// ===== src/sdi_cfg.sv =====
module sdi_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output sdi_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.acmd41_attempts         <= sdi_pkg::RST_ACMD41_ATTEMPTS;
      cfg.acmd41_switch_remaining <= sdi_pkg::RST_SWITCH_REMAIN;
      cfg.cmd1_attempts           <= sdi_pkg::RST_CMD1_ATTEMPTS;
      cfg.block_length            <= sdi_pkg::RST_BLOCK_LENGTH;
    end else if (wr_en) begin
      case (reg_sel)
        sdi_pkg::REG_ACMD41_ATTEMPTS: cfg.acmd41_attempts         <= pwdata[15:0];
        sdi_pkg::REG_SWITCH_REMAIN:   cfg.acmd41_switch_remaining <= pwdata[15:0];
        sdi_pkg::REG_CMD1_ATTEMPTS:   cfg.cmd1_attempts           <= pwdata[15:0];
        sdi_pkg::REG_BLOCK_LENGTH:    cfg.block_length            <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      sdi_pkg::REG_ACMD41_ATTEMPTS: prdata = {16'd0, cfg.acmd41_attempts};
      sdi_pkg::REG_SWITCH_REMAIN:   prdata = {16'd0, cfg.acmd41_switch_remaining};
      sdi_pkg::REG_CMD1_ATTEMPTS:   prdata = {16'd0, cfg.cmd1_attempts};
      sdi_pkg::REG_BLOCK_LENGTH:    prdata = {19'd0, cfg.block_length};
      default:                      prdata = '0;
    endcase
  end

endmodule

// ===== src/sdi_step.sv =====
module sdi_step (
  input  sdi_pkg::cfg_t    cfg,
  input  sdi_pkg::state_t  st,
  input  sdi_pkg::item_t   item,
  output sdi_pkg::state_t  st_next,
  output sdi_pkg::result_t res
);

  logic [1:0]  status;
  logic [5:0]  idx;
  logic [31:0] arg;
  logic        prefix;
  logic        pre;
  logic [2:0]  cause;
  logic        r1_ready;
  logic        v2_echo;
  logic        last_try;
  logic        hcs_flip;
  logic        hcs_acmd;

  assign r1_ready = !item.r1[0];
  assign last_try = st.tries_left <= 16'd1;
  assign v2_echo  = item.resp_ok && (item.r1 == sdi_pkg::R1_IDLE) &&
                    (item.echo_voltage == sdi_pkg::ECHO_VOLT) &&
                    (item.echo_pattern == sdi_pkg::ECHO_PATT);
  assign hcs_flip = !st.arg_switched &&
                    (st.tries_left == cfg.acmd41_switch_remaining);
  assign hcs_acmd = st.hcs_request ^ hcs_flip;

  // next state and command decision
  always_comb begin
    st_next = st;
    status  = sdi_pkg::ST_IGNORE;
    idx     = '0;
    arg     = '0;
    prefix  = 1'b0;
    pre     = 1'b0;
    cause   = sdi_pkg::FC_NONE;
    if (item.operation == sdi_pkg::OP_START) begin
      st_next       = '0;
      st_next.phase = sdi_pkg::PH_CMD0;
      status        = sdi_pkg::ST_ISSUE;
      idx           = sdi_pkg::CMD_GO_IDLE;
      pre           = 1'b1;
    end else begin
      case (st.phase)
        sdi_pkg::PH_CMD0: begin
          if (!item.resp_ok) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD0_SILENT;
          end else if (item.r1 != sdi_pkg::R1_IDLE) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD0_NOIDLE;
          end else begin
            st_next.phase = sdi_pkg::PH_CMD8;
            status        = sdi_pkg::ST_ISSUE;
            idx           = sdi_pkg::CMD_IF_COND;
            arg           = sdi_pkg::IF_COND_ARG;
          end
        end
        sdi_pkg::PH_CMD8: begin
          st_next.version_two  = v2_echo;
          st_next.hcs_request  = v2_echo;
          st_next.arg_switched = 1'b0;
          st_next.tries_left   = cfg.acmd41_attempts;
          st_next.phase        = sdi_pkg::PH_ACMD41;
          status               = sdi_pkg::ST_ISSUE;
          idx                  = sdi_pkg::CMD_APP_OP;
          arg                  = v2_echo ? sdi_pkg::HCS_ARG : '0;
          prefix               = 1'b1;
        end
        sdi_pkg::PH_ACMD41: begin
          if (!item.resp_ok) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_ACMD41_SILENT;
          end else if (r1_ready) begin
            status = sdi_pkg::ST_ISSUE;
            if (st.version_two) begin
              st_next.phase = sdi_pkg::PH_CMD58;
              idx           = sdi_pkg::CMD_READ_OCR;
            end else begin
              st_next.card_high_capacity = 1'b0;
              st_next.phase              = sdi_pkg::PH_CMD16;
              idx                        = sdi_pkg::CMD_BLOCKLEN;
              arg                        = {19'd0, cfg.block_length};
            end
          end else begin
            // capacity argument flips once when the count reaches the switch point
            st_next.hcs_request  = hcs_acmd;
            st_next.arg_switched = st.arg_switched | hcs_flip;
            status               = sdi_pkg::ST_ISSUE;
            if (last_try) begin
              st_next.tries_left = cfg.cmd1_attempts;
              st_next.phase      = sdi_pkg::PH_CMD1;
              idx                = sdi_pkg::CMD_OP_COND;
            end else begin
              st_next.tries_left = st.tries_left - 16'd1;
              idx                = sdi_pkg::CMD_APP_OP;
              arg                = hcs_acmd ? sdi_pkg::HCS_ARG : '0;
              prefix             = 1'b1;
            end
          end
        end
        sdi_pkg::PH_CMD1: begin
          if (!item.resp_ok) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD1_SILENT;
          end else if (r1_ready) begin
            // mmc fallback: always byte addressed
            st_next.version_two        = 1'b0;
            st_next.card_high_capacity = 1'b0;
            st_next.phase              = sdi_pkg::PH_CMD16;
            status                     = sdi_pkg::ST_ISSUE;
            idx                        = sdi_pkg::CMD_BLOCKLEN;
            arg                        = {19'd0, cfg.block_length};
          end else if (last_try) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD1_TIMEOUT;
          end else begin
            st_next.tries_left = st.tries_left - 16'd1;
            status             = sdi_pkg::ST_ISSUE;
            idx                = sdi_pkg::CMD_OP_COND;
          end
        end
        sdi_pkg::PH_CMD58: begin
          if (!item.resp_ok) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD58_SILENT;
          end else if (item.ocr_high[6]) begin
            st_next.card_high_capacity = 1'b1;
            st_next.phase              = sdi_pkg::PH_DONE;
            status                     = sdi_pkg::ST_DONE;
          end else begin
            st_next.card_high_capacity = 1'b0;
            st_next.phase              = sdi_pkg::PH_CMD16;
            status                     = sdi_pkg::ST_ISSUE;
            idx                        = sdi_pkg::CMD_BLOCKLEN;
            arg                        = {19'd0, cfg.block_length};
          end
        end
        sdi_pkg::PH_CMD16: begin
          if (!item.resp_ok || (item.r1 != 8'd0)) begin
            st_next.phase = sdi_pkg::PH_IDLE;
            status        = sdi_pkg::ST_FAIL;
            cause         = sdi_pkg::FC_CMD16_FAIL;
          end else begin
            st_next.phase = sdi_pkg::PH_DONE;
            status        = sdi_pkg::ST_DONE;
          end
        end
        default: begin
          // idle, done or failed: nothing outstanding
          status = sdi_pkg::ST_IGNORE;
        end
      endcase
    end
  end

  // result assembly; command fields are zero unless a command is issued
  always_comb begin
    res.status        = status;
    res.cmd_index     = idx;
    res.cmd_arg       = arg;
    res.cmd_crc       = (status == sdi_pkg::ST_ISSUE) ? sdi_pkg::crc7(idx, arg) : '0;
    res.app_prefix    = prefix;
    res.preamble      = pre;
    res.fail_cause    = cause;
    res.high_capacity = st_next.card_high_capacity;
    res.fast_clock    = st_next.phase == sdi_pkg::PH_DONE;
  end

endmodule

// ===== src/sd_spi_init_sequencer_top.sv =====
// SD card SPI-mode init sequencer. Send a start request, then feed back the parsed
// response to every command the block asks for; each request gives exactly one
// result: the next command (index, argument, CRC7, CMD55 prefix and idle-clock
// preamble flags), done, fail with a cause, or ignored. A request is taken every
// clock cycle unless the result side stalls; its result goes through the input
// register, then one decision step into the result register; the state update in
// that step is what sets the rate. Registers on the APB port: 0x0 ACMD41 tries,
// 0x4 tries-left value at which the ACMD41 capacity argument flips, 0x8 CMD1 tries,
// 0xC CMD16 block length. Write them only while no request is in flight.
module sd_spi_init_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sdi_req_if.sink     req,
  sdi_rsp_if.source   rsp
);

  sdi_pkg::cfg_t    cfg;
  sdi_pkg::state_t  st;
  sdi_pkg::state_t  st_next;
  sdi_pkg::item_t   item;
  sdi_pkg::result_t res_next;
  sdi_pkg::result_t res;
  logic             item_valid;
  logic             res_valid;
  logic             advance;

  assign pready = 1'b1;

  sdi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  sdi_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // the held request moves on when the result register is free or being drained
  assign advance   = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item <= '{operation: req.operation, resp_ok: req.resp_ok, r1: req.r1,
                echo_voltage: req.echo_voltage, echo_pattern: req.echo_pattern,
                ocr_high: req.ocr_high};
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res.status;
  assign rsp.cmd_index     = res.cmd_index;
  assign rsp.cmd_arg       = res.cmd_arg;
  assign rsp.cmd_crc       = res.cmd_crc;
  assign rsp.app_prefix    = res.app_prefix;
  assign rsp.preamble      = res.preamble;
  assign rsp.fail_cause    = res.fail_cause;
  assign rsp.high_capacity = res.high_capacity;
  assign rsp.fast_clock    = res.fast_clock;

endmodule

// ===== src/sdi_checker.sv =====
`include "assert_macros.svh"

module sdi_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [5:0]  cmd_index,
  input logic [31:0] cmd_arg,
  input logic [6:0]  cmd_crc,
  input logic        app_prefix,
  input logic        preamble,
  input logic [2:0]  fail_cause
);

  // command fields stay clear on done, fail and ignored results
  `SDI_ASSERT(a_no_cmd_fields, clk, rst, (rsp_valid && status != sdi_pkg::ST_ISSUE) |-> (cmd_index == 6'd0 && cmd_arg == 32'd0 && cmd_crc == 7'd0 && !app_prefix && !preamble), "command fields set on a non-issue result")

  // a cause is reported exactly on failures
  `SDI_ASSERT(a_cause_on_fail, clk, rst, rsp_valid |-> ((status == sdi_pkg::ST_FAIL) == (fail_cause != sdi_pkg::FC_NONE)), "fail cause does not match status")

  // preamble goes only with CMD0, prefix only with ACMD41
  `SDI_ASSERT(a_flag_cmds, clk, rst, (rsp_valid && (preamble || app_prefix)) |-> (status == sdi_pkg::ST_ISSUE && (preamble ? cmd_index == sdi_pkg::CMD_GO_IDLE : cmd_index == sdi_pkg::CMD_APP_OP)), "prefix or preamble on the wrong command")

  // a stalled result holds
  `SDI_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(cmd_index) && $stable(cmd_arg) && $stable(fail_cause)), "stalled result changed")

endmodule

bind sd_spi_init_sequencer_top sdi_checker u_sdi_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .cmd_index  (rsp.cmd_index),
  .cmd_arg    (rsp.cmd_arg),
  .cmd_crc    (rsp.cmd_crc),
  .app_prefix (rsp.app_prefix),
  .preamble   (rsp.preamble),
  .fail_cause (rsp.fail_cause)
);
